/* rtl/core/ibs_pkg.sv */
package ibs_pkg;

	localparam int LEAD_SPACE_DEPTH = 16;
	localparam int CNT_W = $clog2(LEAD_SPACE_DEPTH + 1);
	localparam int IDX_W = (LEAD_SPACE_DEPTH > 1) ? $clog2(LEAD_SPACE_DEPTH) : 1;

	localparam logic [7:0] BYTE_NL    = 8'd10;
	localparam logic [7:0] BYTE_TAB   = 8'd9;
	localparam logic [7:0] BYTE_SP    = 8'd32;
	localparam logic [7:0] BYTE_OPEN  = 8'd91;
	localparam logic [7:0] BYTE_CLOSE = 8'd93;
	localparam logic [7:0] BYTE_NONE  = 8'd0;

	localparam logic KIND_CONTENT = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic REG_WRAP = 1'b0;

	typedef struct packed {
		logic sep;
		logic close_blk;
		logic open_blk;
		logic lead;
		logic chr;
		logic fin_nl;
		logic fin_close;
	} plan_t;

endpackage

/* rtl/core/indent_block_splitter.sv */
// a request is registered into the phase and plan registers, and each of its results into the output register
// leading whitespace is replayed from a small buffer, one entry per cycle while the output is not stalled
// the input is stalled while a request's results are being sequenced out
// arst_n clears all line and block state and the wrap_brackets register
module indent_block_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_kind,
	output logic        whitespace_truncated,
	output logic        last_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_SEP  = 4'd1;
	localparam logic [3:0] PH_CBR  = 4'd2;
	localparam logic [3:0] PH_CEOB = 4'd3;
	localparam logic [3:0] PH_OBR  = 4'd4;
	localparam logic [3:0] PH_LEAD = 4'd5;
	localparam logic [3:0] PH_CHR  = 4'd6;
	localparam logic [3:0] PH_FNL  = 4'd7;
	localparam logic [3:0] PH_FBR  = 4'd8;
	localparam logic [3:0] PH_FEOB = 4'd9;

	function automatic logic [9:0] enables(input ibs_pkg::plan_t p, input logic wrap);
		logic [9:0] en;
		en          = '0;
		en[PH_SEP]  = p.sep;
		en[PH_CBR]  = p.close_blk && wrap;
		en[PH_CEOB] = p.close_blk;
		en[PH_OBR]  = p.open_blk && wrap;
		en[PH_LEAD] = p.lead;
		en[PH_CHR]  = p.chr;
		en[PH_FNL]  = p.fin_nl;
		en[PH_FBR]  = p.fin_close && wrap;
		en[PH_FEOB] = p.fin_close;
		return en;
	endfunction

	function automatic logic [3:0] pick(input logic [9:0] en, input logic [3:0] cur);
		logic [3:0] res;
		res = PH_IDLE;
		for (int i = 9; i >= 1; i--) begin
			if (en[i] && (4'(i) > cur))
				res = 4'(i);
		end
		return res;
	endfunction

	logic                         wrap_q;
	logic [ibs_pkg::LEAD_SPACE_DEPTH-1:0] kinds_q;
	logic [ibs_pkg::CNT_W-1:0]    lead_cnt_q;
	logic                         cut_q;
	logic                         at_start_q;
	logic                         begins_tab_q;
	logic                         seen_q;
	logic                         block_open_q;
	logic                         sep_pend_q;
	logic                         prev_blank_q;

	logic [3:0]                   phase_q;
	ibs_pkg::plan_t               plan_q;
	logic [7:0]                   byte_q;
	logic                         cut_main_q;
	logic                         cut_fin_q;
	logic [ibs_pkg::CNT_W-1:0]    lead_n_q;
	logic [ibs_pkg::IDX_W-1:0]    idx_q;

	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         out_kind_q;
	logic                         out_cut_q;
	logic                         out_last_q;

	logic                         accept;
	logic                         is_nl;
	logic                         is_ws;
	logic                         text_start;
	logic                         tab_new;
	logic                         cont;
	logic                         overflow;
	ibs_pkg::plan_t               plan_in;
	logic [3:0]                   first_phase;
	logic                         adv;
	logic                         lead_stay;
	logic [3:0]                   next_phase;
	logic [7:0]                   res_byte;
	logic                         res_kind;
	logic                         res_cut;

	assign pready = 1'b1;
	assign prdata = {31'b0, wrap_q};

	assign in_stall             = (phase_q != PH_IDLE);
	assign accept               = in_valid && !in_stall;
	assign out_valid            = out_valid_q;
	assign out_byte             = out_byte_q;
	assign out_kind             = out_kind_q;
	assign whitespace_truncated = out_cut_q;
	assign last_of_run          = out_last_q;

	always_comb begin
		is_nl      = (data_byte == ibs_pkg::BYTE_NL);
		is_ws      = (data_byte == ibs_pkg::BYTE_TAB) || (data_byte == ibs_pkg::BYTE_SP);
		text_start = !is_nl && !seen_q && !is_ws;
		tab_new    = at_start_q ? (data_byte == ibs_pkg::BYTE_TAB) : begins_tab_q;
		cont       = tab_new && !prev_blank_q && block_open_q;
		overflow   = !is_nl && !seen_q && is_ws &&
			(lead_cnt_q >= ibs_pkg::CNT_W'(ibs_pkg::LEAD_SPACE_DEPTH));
		plan_in.sep       = (is_nl && !seen_q && block_open_q) ||
			(text_start && cont && sep_pend_q);
		plan_in.close_blk = text_start && !cont && block_open_q;
		plan_in.open_blk  = text_start && !cont;
		plan_in.lead      = text_start && (lead_cnt_q != '0);
		plan_in.chr       = !is_nl && (seen_q || text_start);
		plan_in.fin_nl    = final_byte && !is_nl && !seen_q && !text_start && block_open_q;
		plan_in.fin_close = final_byte && (block_open_q || text_start);
		first_phase = pick(enables(plan_in, wrap_q), PH_IDLE);
	end

	always_comb begin
		adv        = (phase_q != PH_IDLE) && (!out_valid_q || !out_stall);
		lead_stay  = (phase_q == PH_LEAD) &&
			((ibs_pkg::CNT_W'(idx_q) + ibs_pkg::CNT_W'(1)) < lead_n_q);
		next_phase = lead_stay ? PH_LEAD : pick(enables(plan_q, wrap_q), phase_q);
		res_byte   = ibs_pkg::BYTE_NONE;
		res_kind   = ibs_pkg::KIND_CONTENT;
		res_cut    = cut_main_q;
		case (phase_q)
			PH_SEP:  res_byte = ibs_pkg::BYTE_NL;
			PH_CBR:  res_byte = ibs_pkg::BYTE_CLOSE;
			PH_CEOB: res_kind = ibs_pkg::KIND_END;
			PH_OBR:  res_byte = ibs_pkg::BYTE_OPEN;
			PH_LEAD: res_byte = kinds_q[idx_q] ? ibs_pkg::BYTE_TAB : ibs_pkg::BYTE_SP;
			PH_CHR:  res_byte = byte_q;
			PH_FNL: begin
				res_byte = ibs_pkg::BYTE_NL;
				res_cut  = cut_fin_q;
			end
			PH_FBR: begin
				res_byte = ibs_pkg::BYTE_CLOSE;
				res_cut  = cut_fin_q;
			end
			PH_FEOB: begin
				res_kind = ibs_pkg::KIND_END;
				res_cut  = cut_fin_q;
			end
			default: res_byte = ibs_pkg::BYTE_NONE;
		endcase
	end

	// leading whitespace buffer, valid only below lead_cnt_q
	always_ff @(posedge clk) begin
		if (accept && !is_nl && !seen_q && is_ws && !overflow)
			kinds_q[lead_cnt_q[ibs_pkg::IDX_W-1:0]] <= (data_byte == ibs_pkg::BYTE_TAB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == ibs_pkg::REG_WRAP)) begin
			wrap_q <= pwdata[0];
		end
	end

	// line and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_cnt_q   <= '0;
			cut_q        <= 1'b0;
			at_start_q   <= 1'b1;
			begins_tab_q <= 1'b0;
			seen_q       <= 1'b0;
			block_open_q <= 1'b0;
			sep_pend_q   <= 1'b0;
			prev_blank_q <= 1'b1;
		end else if (accept) begin
			if (final_byte) begin
				lead_cnt_q   <= '0;
				cut_q        <= 1'b0;
				at_start_q   <= 1'b1;
				begins_tab_q <= 1'b0;
				seen_q       <= 1'b0;
				block_open_q <= 1'b0;
				sep_pend_q   <= 1'b0;
				prev_blank_q <= 1'b1;
			end else if (is_nl) begin
				prev_blank_q <= !seen_q;
				if (block_open_q)
					sep_pend_q <= 1'b1;
				lead_cnt_q   <= '0;
				cut_q        <= 1'b0;
				at_start_q   <= 1'b1;
				begins_tab_q <= 1'b0;
				seen_q       <= 1'b0;
			end else begin
				at_start_q   <= 1'b0;
				begins_tab_q <= tab_new;
				if (text_start) begin
					block_open_q <= 1'b1;
					sep_pend_q   <= 1'b0;
					seen_q       <= 1'b1;
				end else if (!seen_q) begin
					if (overflow)
						cut_q <= 1'b1;
					else
						lead_cnt_q <= lead_cnt_q + ibs_pkg::CNT_W'(1);
				end
			end
		end
	end

	// result sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			phase_q <= first_phase;
		end else if (adv) begin
			phase_q <= next_phase;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plan_q     <= plan_in;
			byte_q     <= data_byte;
			cut_main_q <= is_nl ? cut_q : (cut_q || overflow);
			cut_fin_q  <= !is_nl && (cut_q || overflow);
			lead_n_q   <= lead_cnt_q;
			idx_q      <= '0;
		end else if (adv) begin
			if (lead_stay)
				idx_q <= idx_q + ibs_pkg::IDX_W'(1);
			else
				idx_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= res_byte;
			out_kind_q <= res_kind;
			out_cut_q  <= res_cut;
			out_last_q <= (next_phase == PH_IDLE);
		end
	end

	a_lead_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEAD) |-> ((lead_n_q != '0) &&
			(ibs_pkg::CNT_W'(idx_q) < lead_n_q)))
		else $error("lead replay index out of range");

	a_end_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == ibs_pkg::KIND_END)) |->
			(out_byte_q == ibs_pkg::BYTE_NONE))
		else $error("end marker carries a nonzero byte");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_byte) |=> (!block_open_q && prev_blank_q && at_start_q &&
			(lead_cnt_q == '0)))
		else $error("final byte did not clear line and block state");

	a_no_skip_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("pending result dropped while stalled");

	a_lead_buffer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lead_cnt_q <= ibs_pkg::CNT_W'(ibs_pkg::LEAD_SPACE_DEPTH))
		else $error("leading whitespace count past buffer depth");

endmodule

/* test/indent_block_splitter_tb.sv */
`timescale 1ns / 1ps

module indent_block_splitter_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [2:0] WRAP_ADDR = {ibs_pkg::REG_WRAP, 2'b00};

	typedef struct packed {
		logic [7:0] code;
		logic       kind;
		logic       cut;
		logic       last;
	} block_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        out_kind;
	logic        whitespace_truncated;
	logic        last_of_run;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// predicted splitter state
	logic                                 wrap_on = 1'b0;
	logic [ibs_pkg::LEAD_SPACE_DEPTH-1:0] lead_is_tab;
	int                                   lead_cnt = 0;
	logic                                 line_cut = 1'b0;
	logic                                 at_start = 1'b1;
	logic                                 begins_tab = 1'b0;
	logic                                 seen_text = 1'b0;
	logic                                 blk_open = 1'b0;
	logic                                 sep_pend = 1'b0;
	logic                                 prev_blank = 1'b1;

	block_out_t expected_stream[$];
	int         err_count = 0;
	int         cycle_count = 0;
	int         burst_left = 0;
	bit         steady_send = 1'b0;
	int         stall_mode = 0;
	int         stall_mode_left = 0;

	indent_block_splitter u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.data_byte           (data_byte),
		.final_byte          (final_byte),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.out_byte            (out_byte),
		.out_kind            (out_kind),
		.whitespace_truncated(whitespace_truncated),
		.last_of_run         (last_of_run),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void emit_out(input logic [7:0] code, input logic kind);
		block_out_t r;
		r.code = code;
		r.kind = kind;
		r.cut = line_cut;
		r.last = 1'b0;
		expected_stream = {expected_stream, r};
	endfunction

	function automatic void clear_line();
		lead_cnt = 0;
		line_cut = 1'b0;
		at_start = 1'b1;
		begins_tab = 1'b0;
		seen_text = 1'b0;
	endfunction

	function automatic void close_block();
		if (wrap_on)
			emit_out(ibs_pkg::BYTE_CLOSE, ibs_pkg::KIND_CONTENT);
		emit_out(ibs_pkg::BYTE_NONE, ibs_pkg::KIND_END);
		blk_open = 1'b0;
		sep_pend = 1'b0;
	endfunction

	// regroup one accepted request into the block bytes it produces
	function automatic void split_byte(input logic [7:0] b, input logic fin);
		int         n0;
		int         i;
		logic       cont;
		block_out_t r;
		n0 = expected_stream.size();
		if (b == ibs_pkg::BYTE_NL) begin
			if (!seen_text) begin
				if (blk_open)
					emit_out(ibs_pkg::BYTE_NL, ibs_pkg::KIND_CONTENT);
				prev_blank = 1'b1;
			end else begin
				prev_blank = 1'b0;
			end
			if (blk_open)
				sep_pend = 1'b1;
			clear_line();
		end else begin
			if (at_start) begin
				begins_tab = (b == ibs_pkg::BYTE_TAB);
				at_start = 1'b0;
			end
			if (seen_text) begin
				emit_out(b, ibs_pkg::KIND_CONTENT);
			end else if (b == ibs_pkg::BYTE_TAB || b == ibs_pkg::BYTE_SP) begin
				if (lead_cnt < ibs_pkg::LEAD_SPACE_DEPTH) begin
					lead_is_tab[lead_cnt] = (b == ibs_pkg::BYTE_TAB);
					lead_cnt++;
				end else begin
					line_cut = 1'b1;
				end
			end else begin
				cont = begins_tab && !prev_blank && blk_open;
				if (cont) begin
					if (sep_pend)
						emit_out(ibs_pkg::BYTE_NL, ibs_pkg::KIND_CONTENT);
				end else begin
					if (blk_open)
						close_block();
					if (wrap_on)
						emit_out(ibs_pkg::BYTE_OPEN, ibs_pkg::KIND_CONTENT);
					blk_open = 1'b1;
				end
				sep_pend = 1'b0;
				for (i = 0; i < lead_cnt; i++)
					emit_out(lead_is_tab[i] ? ibs_pkg::BYTE_TAB : ibs_pkg::BYTE_SP,
						ibs_pkg::KIND_CONTENT);
				emit_out(b, ibs_pkg::KIND_CONTENT);
				seen_text = 1'b1;
			end
		end
		if (fin) begin
			if (b != ibs_pkg::BYTE_NL && !seen_text && blk_open)
				emit_out(ibs_pkg::BYTE_NL, ibs_pkg::KIND_CONTENT);
			if (blk_open)
				close_block();
			clear_line();
			blk_open = 1'b0;
			sep_pend = 1'b0;
			prev_blank = 1'b1;
		end
		if (expected_stream.size() > n0) begin
			r = expected_stream.pop_back();
			r.last = 1'b1;
			expected_stream = {expected_stream, r};
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		block_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_stream.size() == 0) begin
				$error("unexpected result: out_byte %0d out_kind %0d", out_byte, out_kind);
				err_count++;
			end else begin
				e = expected_stream.pop_front();
				if (out_byte !== e.code) begin
					$error("out_byte expected %0d got %0d", e.code, out_byte);
					err_count++;
				end
				if (out_kind !== e.kind) begin
					$error("out_kind expected %0d got %0d", e.kind, out_kind);
					err_count++;
				end
				if (whitespace_truncated !== e.cut) begin
					$error("whitespace_truncated expected %0d got %0d", e.cut,
						whitespace_truncated);
					err_count++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run expected %0d got %0d", e.last, last_of_run);
					err_count++;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_mode_left <= $urandom_range(20, 200);
		end else begin
			stall_mode_left <= stall_mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= ((cycle_count % 8) < 5);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = steady_send ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (in_stall);
		split_byte(b, fin);
		burst_left--;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_stream.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_wrap(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WRAP_ADDR;
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		wrap_on = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== v) begin
			$error("wrap_brackets expected %0d got %0d", v, prdata[0]);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one text line, optionally ending the source text
	task automatic send_line(input bit ends_text, output int sent);
		logic [7:0] line_q[$];
		int         kind;
		int         lead;
		int         len;
		int         i;
		bit         tab_first;
		kind = $urandom_range(0, 9);
		tab_first = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 11) == 0)
			lead = $urandom_range(14, 20);
		else
			lead = $urandom_range(0, 3);
		if (kind != 0) begin
			for (i = 0; i < lead; i++) begin
				if (i == 0 && tab_first)
					line_q = {line_q, ibs_pkg::BYTE_TAB};
				else
					line_q = {line_q,
						($urandom_range(0, 1) ? ibs_pkg::BYTE_TAB : ibs_pkg::BYTE_SP)};
			end
		end
		if (kind >= 2) begin
			len = $urandom_range(1, 6);
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) == 0)
					line_q = {line_q, 8'($urandom_range(0, 255))};
				else
					line_q = {line_q, 8'($urandom_range(33, 126))};
			end
		end
		if (!ends_text || line_q.size() == 0 || $urandom_range(0, 1))
			line_q = {line_q, ibs_pkg::BYTE_NL};
		sent = line_q.size();
		for (i = 0; i < line_q.size(); i++)
			send_byte(line_q[i], ends_text && (i == line_q.size() - 1));
	endtask

	task automatic test_directed();
		int i;
		send_byte(ibs_pkg::BYTE_NL, 1'b0);
		send_byte(8'd255, 1'b0);
		send_byte(8'd0, 1'b0);
		send_byte(ibs_pkg::BYTE_NL, 1'b0);
		// continuation line whose indent overflows the buffer
		send_byte(ibs_pkg::BYTE_TAB, 1'b0);
		for (i = 0; i < ibs_pkg::LEAD_SPACE_DEPTH; i++)
			send_byte(i[0] ? ibs_pkg::BYTE_TAB : ibs_pkg::BYTE_SP, 1'b0);
		send_byte(8'h7a, 1'b0);
		send_byte(ibs_pkg::BYTE_NL, 1'b0);
		send_byte(ibs_pkg::BYTE_SP, 1'b0);
		send_byte(ibs_pkg::BYTE_NL, 1'b0);
		// tab line after a blank one opens a new block
		send_byte(ibs_pkg::BYTE_TAB, 1'b0);
		send_byte(8'h71, 1'b0);
		send_byte(ibs_pkg::BYTE_NL, 1'b0);
		// whitespace-only tail at the end of the text
		send_byte(ibs_pkg::BYTE_SP, 1'b1);
		wait_drained();
	endtask

	task automatic test_wrap_midblock();
		write_wrap(1'b1);
		send_byte(8'h61, 1'b0);
		wait_drained();
		write_wrap(1'b0);
		send_byte(ibs_pkg::BYTE_NL, 1'b0);
		send_byte(8'h62, 1'b1);
		wait_drained();
		send_byte(8'h63, 1'b0);
		wait_drained();
		write_wrap(1'b1);
		send_byte(ibs_pkg::BYTE_NL, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_text(input int n_items);
		int count;
		int lines;
		int sent;
		int i;
		count = 0;
		while (count < n_items) begin
			steady_send = ($urandom_range(0, 3) == 0);
			lines = $urandom_range(1, 8);
			for (i = 0; i < lines; i++) begin
				send_line(i == lines - 1, sent);
				count += sent;
			end
		end
		wait_drained();
	endtask

	task automatic test_noise(input int n_items);
		int i;
		steady_send = 1'b0;
		for (i = 0; i < n_items; i++)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_wrap(1'b1);
		test_directed();
		test_wrap_midblock();
		write_wrap(1'b0);
		test_random_text(100);
		write_wrap(1'b1);
		test_random_text(100);
		test_noise(40);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ibs_pkg.sv
rtl/core/indent_block_splitter.sv
test/indent_block_splitter_tb.sv
